[rtl/core/tfn_pkg.sv]
// Shared types, codes and constants for the triangle face normal block.
package tfn_pkg;

  // Default coordinate width in bits (signed Q16.16 at 32).
  localparam int CoordWidthDef = 32;

  // Result kinds.
  localparam logic [2:0] KindFace     = 3'd0;
  localparam logic [2:0] KindEdgeAb   = 3'd1;
  localparam logic [2:0] KindEdgeBc   = 3'd2;
  localparam logic [2:0] KindEdgeCa   = 3'd3;
  localparam logic [2:0] KindCentroid = 3'd4;

  // Steps of the back-end sequencer.
  localparam logic [2:0] StepAb     = 3'd0;
  localparam logic [2:0] StepAc     = 3'd1;
  localparam logic [2:0] StepBc     = 3'd2;
  localparam logic [2:0] StepFace   = 3'd3;
  localparam logic [2:0] StepEdgeAb = 3'd4;
  localparam logic [2:0] StepEdgeBc = 3'd5;
  localparam logic [2:0] StepEdgeCa = 3'd6;

  typedef logic signed [63:0] wide_t;
  typedef logic signed [31:0] unit_t;

  typedef struct packed {
    wide_t x;
    wide_t y;
    wide_t z;
  } wvec_t;

  typedef struct packed {
    unit_t x;
    unit_t y;
    unit_t z;
  } uvec_t;

  typedef struct packed {
    wvec_t dab;
    wvec_t dac;
    wvec_t dbc;
  } diff_t;

  typedef enum logic [2:0] {
    N_IDLE, N_SHIFT, N_SQ, N_SQRT, N_DINIT, N_DIV, N_DONE
  } norm_state_t;

  typedef enum logic [2:0] {
    B_IDLE, B_NSTART, B_NWAIT, B_CROSS, B_EMIT, B_CEN
  } back_state_t;

endpackage

[rtl/core/triangle_face_normals.sv]
// Triangle face normal, edge normals and centroid: top level.
// Each triangle gives five result words. The back end works on one triangle at a time,
// and its shared normalizer, with a 32-step square root and a 32-step division, runs
// seven times per item; a zero vector skips the root and the division.
// The front end and a two-entry queue keep taking triangles while the back end works.
// Reset: synchronous, active low; clears the handshake flags and the state machine states.
module triangle_face_normals #(
  parameter int COORD_WIDTH = tfn_pkg::CoordWidthDef
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_a_x,
  input  logic signed [COORD_WIDTH-1:0] in_a_y,
  input  logic signed [COORD_WIDTH-1:0] in_a_z,
  input  logic signed [COORD_WIDTH-1:0] in_b_x,
  input  logic signed [COORD_WIDTH-1:0] in_b_y,
  input  logic signed [COORD_WIDTH-1:0] in_b_z,
  input  logic signed [COORD_WIDTH-1:0] in_c_x,
  input  logic signed [COORD_WIDTH-1:0] in_c_y,
  input  logic signed [COORD_WIDTH-1:0] in_c_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    out_kind,
  output logic signed [31:0]            out_vec_x,
  output logic signed [31:0]            out_vec_y,
  output logic signed [31:0]            out_vec_z,
  output logic                          out_last
);
  import tfn_pkg::*;

  localparam int SumW = COORD_WIDTH + 3;
  localparam int QWidth = $bits(diff_t) + 3 * SumW;

  logic              f_valid, f_stall;
  diff_t             f_diff, b_diff;
  logic [3*SumW-1:0] f_sum, b_sum;
  logic [QWidth-1:0] q_rd;
  logic              q_valid, q_pop;

  tfn_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_a_x     (in_a_x),
    .in_a_y     (in_a_y),
    .in_a_z     (in_a_z),
    .in_b_x     (in_b_x),
    .in_b_y     (in_b_y),
    .in_b_z     (in_b_z),
    .in_c_x     (in_c_x),
    .in_c_y     (in_c_y),
    .in_c_z     (in_c_z),
    .push_valid (f_valid),
    .push_stall (f_stall),
    .push_diff  (f_diff),
    .push_sum   (f_sum)
  );

  tfn_queue #(.WIDTH(QWidth)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_stall (f_stall),
    .wr_data  ({f_diff, f_sum}),
    .rd_valid (q_valid),
    .rd_pop   (q_pop),
    .rd_data  (q_rd)
  );

  assign b_diff = q_rd[QWidth-1:3*SumW];
  assign b_sum  = q_rd[3*SumW-1:0];

  tfn_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_diff    (b_diff),
    .q_sum     (b_sum),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_kind  (out_kind),
    .out_vec_x (out_vec_x),
    .out_vec_y (out_vec_y),
    .out_vec_z (out_vec_z),
    .out_last  (out_last)
  );

endmodule

[rtl/core/tfn_front.sv]
// Front end: accepts a triangle word and forms edge differences and vertex sums.
module tfn_front #(
  parameter int COORD_WIDTH = tfn_pkg::CoordWidthDef
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_a_x,
  input  logic signed [COORD_WIDTH-1:0] in_a_y,
  input  logic signed [COORD_WIDTH-1:0] in_a_z,
  input  logic signed [COORD_WIDTH-1:0] in_b_x,
  input  logic signed [COORD_WIDTH-1:0] in_b_y,
  input  logic signed [COORD_WIDTH-1:0] in_b_z,
  input  logic signed [COORD_WIDTH-1:0] in_c_x,
  input  logic signed [COORD_WIDTH-1:0] in_c_y,
  input  logic signed [COORD_WIDTH-1:0] in_c_z,
  output logic                          push_valid,
  input  logic                          push_stall,
  output tfn_pkg::diff_t                push_diff,
  output logic [3*(COORD_WIDTH+3)-1:0]  push_sum
);
  import tfn_pkg::*;

  localparam int Pre = (COORD_WIDTH > 61) ? COORD_WIDTH - 61 : 0;
  localparam int SumW = COORD_WIDTH + 3;

  logic                   fr_valid_r, fr_valid_nxt;
  diff_t                  fr_diff_r, fr_diff_nxt;
  logic [3*SumW-1:0]      fr_sum_r, fr_sum_nxt;
  wide_t                  sa_x, sa_y, sa_z, sb_x, sb_y, sb_z, sc_x, sc_y, sc_z;
  logic signed [SumW-1:0] sum_x, sum_y, sum_z;
  logic                   accept, push;

  assign accept   = in_valid && !in_stall;
  assign push     = fr_valid_r && !push_stall;
  assign in_stall = fr_valid_r && push_stall;

  // Coordinates are sign-extended and, when very wide, pre-scaled by a floor shift.
  always_comb begin
    sa_x = 64'(in_a_x) >>> Pre;
    sa_y = 64'(in_a_y) >>> Pre;
    sa_z = 64'(in_a_z) >>> Pre;
    sb_x = 64'(in_b_x) >>> Pre;
    sb_y = 64'(in_b_y) >>> Pre;
    sb_z = 64'(in_b_z) >>> Pre;
    sc_x = 64'(in_c_x) >>> Pre;
    sc_y = 64'(in_c_y) >>> Pre;
    sc_z = 64'(in_c_z) >>> Pre;
    // The centroid rounds to nearest, so the sum carries a bias of one.
    sum_x = SumW'(in_a_x) + SumW'(in_b_x) + SumW'(in_c_x) + SumW'(1);
    sum_y = SumW'(in_a_y) + SumW'(in_b_y) + SumW'(in_c_y) + SumW'(1);
    sum_z = SumW'(in_a_z) + SumW'(in_b_z) + SumW'(in_c_z) + SumW'(1);
  end

  // Next value of the holding stage.
  always_comb begin
    fr_valid_nxt = fr_valid_r;
    fr_diff_nxt  = fr_diff_r;
    fr_sum_nxt   = fr_sum_r;
    if (push) begin
      fr_valid_nxt = 1'b0;
    end
    if (accept) begin
      fr_valid_nxt     = 1'b1;
      fr_diff_nxt.dab  = '{x: sb_x - sa_x, y: sb_y - sa_y, z: sb_z - sa_z};
      fr_diff_nxt.dac  = '{x: sc_x - sa_x, y: sc_y - sa_y, z: sc_z - sa_z};
      fr_diff_nxt.dbc  = '{x: sc_x - sb_x, y: sc_y - sb_y, z: sc_z - sb_z};
      fr_sum_nxt       = {sum_z, sum_y, sum_x};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
    fr_diff_r <= fr_diff_nxt;
    fr_sum_r  <= fr_sum_nxt;
  end

  assign push_valid = fr_valid_r;
  assign push_diff  = fr_diff_r;
  assign push_sum   = fr_sum_r;

endmodule

[rtl/core/tfn_queue.sv]
// Two-entry queue that decouples the front end from the back end.
module tfn_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_stall,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_pop,
  output logic [WIDTH-1:0] rd_data
);
  import tfn_pkg::*;

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             wr_en, rd_en;

  assign wr_stall = cnt_r[1];
  assign rd_valid = (cnt_r != 2'd0);
  assign wr_en    = wr_valid && !wr_stall;
  assign rd_en    = rd_pop && rd_valid;
  assign rd_data  = mem[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_en ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = rd_en ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(wr_en) - 2'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage write.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

endmodule

[rtl/core/tfn_norm.sv]
// Iterative vector normalizer: block shift, sum of squares, square root, division.
module tfn_norm (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  tfn_pkg::wvec_t vin,
  output logic           done,
  output tfn_pkg::uvec_t vout
);
  import tfn_pkg::*;

  localparam logic [62:0] MagHi = 63'(1) << 31;
  localparam logic [62:0] MagLo = 63'(1) << 30;
  localparam logic [31:0] QMax  = 32'(1) << 30;

  norm_state_t st_r, st_nxt;
  logic [62:0] m_r [3];
  logic        neg_r [3];
  logic [5:0]  cnt_r;
  logic [61:0] prod_r;
  logic [63:0] s_r, rem_r, res_r, bit_r;
  logic [33:0] drem_r [3];
  logic [31:0] lo_r [3];
  logic [31:0] q_r [3];
  logic [62:0] mx;
  logic        all_zero;
  wide_t       vc [3];
  logic [31:0] qc [3];
  unit_t       oc [3];

  assign vc[0] = vin.x;
  assign vc[1] = vin.y;
  assign vc[2] = vin.z;

  // Largest magnitude and zero test.
  always_comb begin
    mx = m_r[0];
    if (m_r[1] > mx) begin
      mx = m_r[1];
    end
    if (m_r[2] > mx) begin
      mx = m_r[2];
    end
    all_zero = (vc[0] == '0) && (vc[1] == '0) && (vc[2] == '0);
  end

  // Next state.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      N_IDLE: begin
        if (start) begin
          st_nxt = all_zero ? N_DONE : N_SHIFT;
        end
      end
      N_SHIFT: begin
        if (mx < MagHi && mx >= MagLo) begin
          st_nxt = N_SQ;
        end
      end
      N_SQ: begin
        if (cnt_r == 6'd3) begin
          st_nxt = N_SQRT;
        end
      end
      N_SQRT: begin
        if (cnt_r == 6'd31) begin
          st_nxt = N_DINIT;
        end
      end
      N_DINIT: st_nxt = N_DIV;
      N_DIV: begin
        if (cnt_r == 6'd31) begin
          st_nxt = N_DONE;
        end
      end
      N_DONE:  st_nxt = N_IDLE;
      default: st_nxt = N_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= N_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // Datapath: each state advances one step of its loop per cycle.
  always_ff @(posedge clk) begin
    logic [33:0] t;
    logic [61:0] num;
    case (st_r)
      N_IDLE: begin
        for (int i = 0; i < 3; i++) begin
          neg_r[i] <= vc[i][63];
          m_r[i]   <= vc[i][63] ? 63'(-vc[i]) : 63'(vc[i]);
          q_r[i]   <= '0;
        end
      end
      N_SHIFT: begin
        cnt_r <= '0;
        s_r   <= '0;
        for (int i = 0; i < 3; i++) begin
          if (mx >= MagHi) begin
            m_r[i] <= m_r[i] >> 1;
          end else if (mx < MagLo) begin
            m_r[i] <= m_r[i] << 1;
          end
        end
      end
      N_SQ: begin
        if (cnt_r != 6'd3) begin
          prod_r <= 62'(m_r[cnt_r[1:0]][30:0]) * 62'(m_r[cnt_r[1:0]][30:0]);
        end
        if (cnt_r != 6'd0) begin
          s_r <= s_r + 64'(prod_r);
        end
        if (cnt_r == 6'd3) begin
          rem_r <= s_r + 64'(prod_r);
          res_r <= '0;
          bit_r <= 64'(1) << 62;
          cnt_r <= '0;
        end else begin
          cnt_r <= cnt_r + 6'd1;
        end
      end
      N_SQRT: begin
        if (rem_r >= res_r + bit_r) begin
          rem_r <= rem_r - (res_r + bit_r);
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
        cnt_r <= (cnt_r == 6'd31) ? 6'd0 : cnt_r + 6'd1;
      end
      N_DINIT: begin
        // Numerator is m * 2^30 plus half the root; its top part seeds the remainder.
        for (int i = 0; i < 3; i++) begin
          num       = {1'b0, m_r[i][30:0], 30'd0} + 62'(res_r[63:1]);
          drem_r[i] <= 34'(num[61:32]);
          lo_r[i]   <= num[31:0];
          q_r[i]    <= '0;
        end
        cnt_r <= '0;
      end
      N_DIV: begin
        for (int i = 0; i < 3; i++) begin
          t = {drem_r[i][32:0], lo_r[i][31]};
          if (t >= 34'(res_r[32:0])) begin
            drem_r[i] <= t - 34'(res_r[32:0]);
            q_r[i]    <= {q_r[i][30:0], 1'b1};
          end else begin
            drem_r[i] <= t;
            q_r[i]    <= {q_r[i][30:0], 1'b0};
          end
          lo_r[i] <= lo_r[i] << 1;
        end
        cnt_r <= cnt_r + 6'd1;
      end
      default: begin
      end
    endcase
  end

  // Clamp to one and restore the signs.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qc[i] = (q_r[i] > QMax) ? QMax : q_r[i];
      oc[i] = neg_r[i] ? -unit_t'(qc[i]) : unit_t'(qc[i]);
    end
  end

  assign done = (st_r == N_DONE);
  assign vout = '{x: oc[0], y: oc[1], z: oc[2]};

endmodule

[rtl/core/tfn_back.sv]
// Back end: sequences normalizations and cross products, divides the sums by three.
module tfn_back #(
  parameter int COORD_WIDTH = tfn_pkg::CoordWidthDef
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  output logic                         q_pop,
  input  tfn_pkg::diff_t               q_diff,
  input  logic [3*(COORD_WIDTH+3)-1:0] q_sum,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [2:0]                   out_kind,
  output logic signed [31:0]           out_vec_x,
  output logic signed [31:0]           out_vec_y,
  output logic signed [31:0]           out_vec_z,
  output logic                         out_last
);
  import tfn_pkg::*;

  localparam int SumW = COORD_WIDTH + 3;
  localparam int XW   = SumW + 1;
  localparam int QW   = XW + 1;

  back_state_t st_r, st_nxt;
  logic [2:0]  step_r;
  logic [2:0]  ccnt_r;
  diff_t       diff_r;
  uvec_t       ab_r, ac_r, bc_r, n_r, res_r;
  wide_t       acc_r [3];
  wide_t       prod_r;
  unit_t       mu, mv;
  uvec_t       cu, cv;
  logic        norm_start, norm_done;
  wvec_t       norm_in;
  uvec_t       norm_out;
  logic        out_free;
  logic        load;

  // Centroid divider lanes.
  logic [XW-1:0]          xd_r [3];
  logic [XW-1:0]          qd_r [3];
  logic [6:0]             rr_r [3];
  logic                   cneg_r [3];
  logic [2:0]             dcnt_r;
  logic                   dbusy_r;
  logic signed [SumW-1:0] sx [3];
  logic [XW-1:0]          qsh [3];
  logic [12:0]            rfix [3];
  logic signed [QW-1:0]   qs [3];
  logic [QW+31:0]         qext [3];

  // Output register.
  logic        ov_r;
  logic [2:0]  okind_r;
  unit_t       ox_r, oy_r, oz_r;
  logic        olast_r;

  assign out_free = !ov_r || !out_stall;
  assign load     = (st_r == B_IDLE) && q_valid;
  assign q_pop    = load;

  tfn_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .start (norm_start),
    .vin   (norm_in),
    .done  (norm_done),
    .vout  (norm_out)
  );

  // Normalizer operand.
  always_comb begin
    case (step_r)
      StepAb:  norm_in = diff_r.dab;
      StepAc:  norm_in = diff_r.dac;
      StepBc:  norm_in = diff_r.dbc;
      default: norm_in = '{x: acc_r[0], y: acc_r[1], z: acc_r[2]};
    endcase
  end

  // Cross product operands for the face step and each edge step.
  always_comb begin
    case (step_r)
      StepFace: begin
        cu = ab_r;
        cv = ac_r;
      end
      StepEdgeAb: begin
        cu = ab_r;
        cv = n_r;
      end
      StepEdgeBc: begin
        cu = bc_r;
        cv = n_r;
      end
      default: begin
        cu = n_r;
        cv = ac_r;
      end
    endcase
    case (ccnt_r)
      3'd0: begin
        mu = cu.y;
        mv = cv.z;
      end
      3'd1: begin
        mu = cu.z;
        mv = cv.y;
      end
      3'd2: begin
        mu = cu.z;
        mv = cv.x;
      end
      3'd3: begin
        mu = cu.x;
        mv = cv.z;
      end
      3'd4: begin
        mu = cu.x;
        mv = cv.y;
      end
      default: begin
        mu = cu.y;
        mv = cv.x;
      end
    endcase
  end

  // Sequencer next state.
  always_comb begin
    st_nxt     = st_r;
    norm_start = 1'b0;
    case (st_r)
      B_IDLE: begin
        if (q_valid) begin
          st_nxt = B_NSTART;
        end
      end
      B_NSTART: begin
        norm_start = 1'b1;
        st_nxt     = B_NWAIT;
      end
      B_NWAIT: begin
        if (norm_done) begin
          if (step_r == StepAb || step_r == StepAc) begin
            st_nxt = B_NSTART;
          end else if (step_r == StepBc) begin
            st_nxt = B_CROSS;
          end else begin
            st_nxt = B_EMIT;
          end
        end
      end
      B_CROSS: begin
        if (ccnt_r == 3'd6) begin
          st_nxt = B_NSTART;
        end
      end
      B_EMIT: begin
        if (out_free) begin
          st_nxt = (step_r == StepEdgeCa) ? B_CEN : B_CROSS;
        end
      end
      B_CEN: begin
        if (out_free && !dbusy_r) begin
          st_nxt = B_IDLE;
        end
      end
      default: st_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // Sequencer datapath.
  always_ff @(posedge clk) begin
    if (load) begin
      diff_r <= q_diff;
      step_r <= StepAb;
    end
    if (st_r == B_NWAIT && norm_done) begin
      case (step_r)
        StepAb:   ab_r <= norm_out;
        StepAc:   ac_r <= norm_out;
        StepBc:   bc_r <= norm_out;
        StepFace: n_r  <= norm_out;
        default:  ;
      endcase
      res_r <= norm_out;
      if (step_r == StepAb || step_r == StepAc || step_r == StepBc) begin
        step_r <= step_r + 3'd1;
        ccnt_r <= '0;
      end
    end
    if (st_r == B_EMIT && out_free) begin
      ccnt_r <= '0;
      if (step_r != StepEdgeCa) begin
        step_r <= step_r + 3'd1;
      end
    end
    // Cross product: one product a cycle, accumulated the cycle after.
    if (st_r == B_CROSS) begin
      if (ccnt_r != 3'd6) begin
        prod_r <= 64'(mu) * 64'(mv);
      end
      if (ccnt_r == 3'd0) begin
        for (int i = 0; i < 3; i++) begin
          acc_r[i] <= '0;
        end
      end else begin
        if (ccnt_r[0]) begin
          acc_r[2'((ccnt_r - 3'd1) >> 1)] <= acc_r[2'((ccnt_r - 3'd1) >> 1)] + prod_r;
        end else begin
          acc_r[2'((ccnt_r - 3'd1) >> 1)] <= acc_r[2'((ccnt_r - 3'd1) >> 1)] - prod_r;
        end
      end
      ccnt_r <= ccnt_r + 3'd1;
    end
  end

  // Centroid: the quotient by three is built from x/4 + x/16 + ... by doubling the
  // number of terms each cycle, which stays a few units low; the remainder x - 3q is
  // then small and one multiply by 43/128 finishes the floor division.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sx[i] = q_sum[i*SumW +: SumW];
      case (dcnt_r)
        3'd1:    qsh[i] = qd_r[i] >> 4;
        3'd2:    qsh[i] = qd_r[i] >> 8;
        3'd3:    qsh[i] = qd_r[i] >> 16;
        3'd4:    qsh[i] = qd_r[i] >> 32;
        default: qsh[i] = qd_r[i] >> 64;
      endcase
      rfix[i] = 13'(rr_r[i]) * 13'd43;
      qs[i]   = cneg_r[i] ? -QW'(qd_r[i]) : QW'(qd_r[i]);
      qext[i] = {{32{qs[i][QW-1]}}, qs[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbusy_r <= 1'b0;
    end else if (load) begin
      dbusy_r <= 1'b1;
    end else if (dbusy_r && dcnt_r == 3'd7) begin
      dbusy_r <= 1'b0;
    end
    if (load) begin
      dcnt_r <= '0;
      for (int i = 0; i < 3; i++) begin
        cneg_r[i] <= sx[i][SumW-1];
        // A negative value rounds toward minus infinity: divide |x| + 2 instead.
        xd_r[i]   <= sx[i][SumW-1] ? XW'(-sx[i]) + XW'(2) : XW'(sx[i]);
      end
    end else if (dbusy_r) begin
      dcnt_r <= dcnt_r + 3'd1;
      for (int i = 0; i < 3; i++) begin
        case (dcnt_r)
          3'd0:    qd_r[i] <= (xd_r[i] >> 2) + (xd_r[i] >> 4);
          3'd6:    rr_r[i] <= 7'(xd_r[i] - qd_r[i] - (qd_r[i] << 1));
          3'd7:    qd_r[i] <= qd_r[i] + XW'(rfix[i][12:7]);
          default: qd_r[i] <= qd_r[i] + qsh[i];
        endcase
      end
    end
  end

  // Output register loads a result word in the emit or centroid state when the slot is free or being taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (st_r == B_EMIT && out_free) begin
      ov_r <= 1'b1;
    end else if (st_r == B_CEN && out_free && !dbusy_r) begin
      ov_r <= 1'b1;
    end else if (!out_stall) begin
      ov_r <= 1'b0;
    end
    if (st_r == B_EMIT && out_free) begin
      case (step_r)
        StepFace:   okind_r <= KindFace;
        StepEdgeAb: okind_r <= KindEdgeAb;
        StepEdgeBc: okind_r <= KindEdgeBc;
        default:    okind_r <= KindEdgeCa;
      endcase
      ox_r    <= res_r.x;
      oy_r    <= res_r.y;
      oz_r    <= res_r.z;
      olast_r <= 1'b0;
    end else if (st_r == B_CEN && out_free && !dbusy_r) begin
      okind_r <= KindCentroid;
      ox_r    <= qext[0][31:0];
      oy_r    <= qext[1][31:0];
      oz_r    <= qext[2][31:0];
      olast_r <= 1'b1;
    end
  end

  assign out_valid = ov_r;
  assign out_kind  = okind_r;
  assign out_vec_x = ox_r;
  assign out_vec_y = oy_r;
  assign out_vec_z = oz_r;
  assign out_last  = olast_r;

endmodule

[dv/triangle_face_normals_tb.sv]
// Self-checking testbench for the triangle face normal, edge normal and centroid block.
`timescale 1ns / 100ps

module triangle_face_normals_tb;
  import tfn_pkg::*;

  localparam int  CW        = 32;
  localparam int  N_RANDOM  = 290;
  localparam int  HOLD_AT   = 150;
  localparam int  CALM_LEFT = 40;
  localparam int  DRAIN_CYC = 600;
  localparam longint ONE_Q30 = 64'sd1 << 30;

  typedef struct {
    logic signed [CW-1:0] c [9];
  } tri_t;

  typedef struct {
    logic [2:0]   kind;
    logic [31:0]  x;
    logic [31:0]  y;
    logic [31:0]  z;
    logic         last;
  } word_t;

  typedef struct {
    longint x;
    longint y;
    longint z;
  } v3_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [CW-1:0] in_a_x, in_a_y, in_a_z;
  logic signed [CW-1:0] in_b_x, in_b_y, in_b_z;
  logic signed [CW-1:0] in_c_x, in_c_y, in_c_z;
  logic out_valid;
  logic out_stall;
  logic [2:0] out_kind;
  logic signed [31:0] out_vec_x, out_vec_y, out_vec_z;
  logic out_last;

  tri_t  pending_tris [$];
  word_t expected_words [$];
  tri_t  cur_tri;
  int    errors = 0;
  int    sent = 0;
  int    in_gap = 0;
  int    out_gap = 0;
  bit    tri_taken = 0;
  bit    held_once = 0;

  triangle_face_normals #(.COORD_WIDTH(CW)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_a_x(in_a_x), .in_a_y(in_a_y), .in_a_z(in_a_z),
    .in_b_x(in_b_x), .in_b_y(in_b_y), .in_b_z(in_b_z),
    .in_c_x(in_c_x), .in_c_y(in_c_y), .in_c_z(in_c_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_kind(out_kind), .out_vec_x(out_vec_x), .out_vec_y(out_vec_y),
    .out_vec_z(out_vec_z), .out_last(out_last)
  );

  // Clock generation.
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Bitwise integer square root of a 64-bit value.
  function automatic longint unsigned isqrt(input longint unsigned s);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (s >= res + bitv) begin
        s = s - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Fixed-point normalization to a Q2.30 unit vector; zero stays zero.
  function automatic v3_t unit_of(input v3_t v);
    longint unsigned m [3];
    longint unsigned mx, s, r, q;
    bit neg [3];
    longint comp [3];
    longint o [3];
    v3_t res;
    comp[0] = v.x;
    comp[1] = v.y;
    comp[2] = v.z;
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = comp[i] < 0;
      m[i] = neg[i] ? longint'(-comp[i]) : longint'(comp[i]);
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      res.x = 0;
      res.y = 0;
      res.z = 0;
      return res;
    end
    while (mx >= (64'd1 << 31)) begin
      mx = mx >> 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
    end
    while (mx < (64'd1 << 30)) begin
      mx = mx << 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
    end
    s = 0;
    for (int i = 0; i < 3; i++) s = s + m[i] * m[i];
    r = isqrt(s);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << 30) + (r >> 1)) / r;
      if (q > ONE_Q30) q = ONE_Q30;
      o[i] = neg[i] ? -longint'(q) : longint'(q);
    end
    res.x = o[0];
    res.y = o[1];
    res.z = o[2];
    return res;
  endfunction

  // Exact cross product of two unit vectors, then normalized.
  function automatic v3_t unit_cross(input v3_t a, input v3_t b);
    v3_t c;
    c.x = a.y * b.z - a.z * b.y;
    c.y = a.z * b.x - a.x * b.z;
    c.z = a.x * b.y - a.y * b.x;
    return unit_of(c);
  endfunction

  // One centroid component: sum of floored thirds plus the rounded remainder.
  function automatic longint third_sum(input longint p0, input longint p1, input longint p2);
    longint p [3];
    longint q, r, qs, rs;
    p[0] = p0;
    p[1] = p1;
    p[2] = p2;
    qs = 0;
    rs = 0;
    for (int i = 0; i < 3; i++) begin
      q = p[i] / 3;
      r = p[i] % 3;
      if (r < 0) begin
        q = q - 1;
        r = r + 3;
      end
      qs = qs + q;
      rs = rs + r;
    end
    return qs + (rs + 1) / 3;
  endfunction

  function automatic word_t make_word(input logic [2:0] k, input v3_t v, input logic lst);
    word_t w;
    w.kind = k;
    w.x = v.x[31:0];
    w.y = v.y[31:0];
    w.z = v.z[31:0];
    w.last = lst;
    return w;
  endfunction

  // Append one expected word at the tail of the scoreboard.
  task automatic store_word(input word_t w);
    expected_words = {expected_words, w};
  endtask

  // Queue the five words one triangle produces.
  task automatic predict_normals(input tri_t t);
    longint p [9];
    v3_t dab, dac, dbc, ab, ac, bc, n, cen;
    for (int i = 0; i < 9; i++) p[i] = longint'(t.c[i]);
    dab.x = p[3] - p[0]; dab.y = p[4] - p[1]; dab.z = p[5] - p[2];
    dac.x = p[6] - p[0]; dac.y = p[7] - p[1]; dac.z = p[8] - p[2];
    dbc.x = p[6] - p[3]; dbc.y = p[7] - p[4]; dbc.z = p[8] - p[5];
    ab = unit_of(dab);
    ac = unit_of(dac);
    bc = unit_of(dbc);
    n = unit_cross(ab, ac);
    store_word(make_word(KindFace, n, 1'b0));
    store_word(make_word(KindEdgeAb, unit_cross(ab, n), 1'b0));
    store_word(make_word(KindEdgeBc, unit_cross(bc, n), 1'b0));
    store_word(make_word(KindEdgeCa, unit_cross(n, ac), 1'b0));
    cen.x = third_sum(p[0], p[3], p[6]);
    cen.y = third_sum(p[1], p[4], p[7]);
    cen.z = third_sum(p[2], p[5], p[8]);
    store_word(make_word(KindCentroid, cen, 1'b1));
  endtask

  task automatic add_tri(input logic signed [CW-1:0] ax, ay, az, bx, by, bz, cx, cy, cz);
    tri_t t;
    t.c[0] = ax; t.c[1] = ay; t.c[2] = az;
    t.c[3] = bx; t.c[4] = by; t.c[5] = bz;
    t.c[6] = cx; t.c[7] = cy; t.c[8] = cz;
    pending_tris = {pending_tris, t};
  endtask

  function automatic logic signed [CW-1:0] rand_coord(input int style);
    case (style)
      0: return $signed($urandom_range(32'h000fffff)) - 32'sh00080000;
      1: return $signed($urandom_range(32'h03ffffff)) - 32'sh02000000;
      default: return $signed($urandom());
    endcase
  endfunction

  // Input side: sample the handshake at the rising edge and predict.
  always @(posedge clk) begin
    tri_taken = rst_n && in_valid && !in_stall;
    if (tri_taken) predict_normals(cur_tri);
  end

  // Input driver: updates at the falling edge.
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !tri_taken)) begin
      if (in_gap > 0) begin
        in_gap = in_gap - 1;
        in_valid <= 1'b0;
      end else if (sent == HOLD_AT && !held_once && expected_words.size() != 0) begin
        // Hold off once until the block has fully drained.
        in_valid <= 1'b0;
      end else if (pending_tris.size() != 0) begin
        if (sent == HOLD_AT) held_once = 1;
        cur_tri = pending_tris.pop_front();
        sent = sent + 1;
        {in_a_x, in_a_y, in_a_z} <= {cur_tri.c[0], cur_tri.c[1], cur_tri.c[2]};
        {in_b_x, in_b_y, in_b_z} <= {cur_tri.c[3], cur_tri.c[4], cur_tri.c[5]};
        {in_c_x, in_c_y, in_c_z} <= {cur_tri.c[6], cur_tri.c[7], cur_tri.c[8]};
        in_valid <= 1'b1;
        if (pending_tris.size() > CALM_LEFT && $urandom_range(3) == 0)
          in_gap = $urandom_range(5, 1);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output stall generator: random bursts, none near the end.
  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_gap = out_gap - 1;
      out_stall <= 1'b1;
    end else if (pending_tris.size() > CALM_LEFT && $urandom_range(7) == 0) begin
      out_gap = $urandom_range(4, 0);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Result monitor: compare each accepted word with the oldest expectation.
  always @(posedge clk) begin
    word_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        $error("unexpected result word: kind %0d", out_kind);
        errors++;
      end else begin
        w = expected_words.pop_front();
        if (out_kind !== w.kind) begin
          $error("kind: expected %0d, actual %0d", w.kind, out_kind); errors++;
        end
        if (out_vec_x !== w.x) begin
          $error("vec_x: expected %h, actual %h", w.x, out_vec_x); errors++;
        end
        if (out_vec_y !== w.y) begin
          $error("vec_y: expected %h, actual %h", w.y, out_vec_y); errors++;
        end
        if (out_vec_z !== w.z) begin
          $error("vec_z: expected %h, actual %h", w.z, out_vec_z); errors++;
        end
        if (out_last !== w.last) begin
          $error("last: expected %0d, actual %0d", w.last, out_last); errors++;
        end
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int style;
    logic signed [CW-1:0] v [9];
    logic signed [CW-1:0] mx, mn;
    mx = 32'sh7fffffff;
    mn = 32'sh80000000;
    rst_n = 1'b0;
    in_valid = 1'b0;
    out_stall = 1'b0;
    {in_a_x, in_a_y, in_a_z, in_b_x, in_b_y, in_b_z, in_c_x, in_c_y, in_c_z} = '0;

    // Directed triangles: degenerate shapes, extremes and plain cases.
    add_tri(0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_tri(mx, mx, mx, mx, mx, mx, mx, mx, mx);
    add_tri(mn, mn, mn, mn, mn, mn, mn, mn, mn);
    add_tri(0, 0, 0, 32'sh10000, 0, 0, 0, 32'sh10000, 0);
    add_tri(0, 0, 0, 0, 32'sh10000, 0, 32'sh10000, 0, 0);
    add_tri(mn, mn, mn, mx, mn, mn, mn, mx, mn);
    add_tri(mx, mx, mx, mn, mx, mx, mx, mn, mx);
    add_tri(mn, 0, mx, mx, mn, 0, 0, mx, mn);
    add_tri(mn, mn, mn, mx, mx, mx, 0, 0, 0);
    add_tri(0, 0, 0, 32'sh10000, 32'sh10000, 32'sh10000, 32'sh20000, 32'sh20000, 32'sh20000);
    add_tri(5, 7, 9, 5, 7, 9, 100, -3, 42);
    add_tri(5, 7, 9, 100, -3, 42, 5, 7, 9);
    add_tri(100, -3, 42, 5, 7, 9, 5, 7, 9);
    add_tri(0, 0, 0, 1, 0, 0, 0, 0, 1);
    add_tri(-1, -1, -1, 1, 1, -1, 1, -1, 1);
    add_tri(1, 1, 1, 2, 2, 2, 0, 0, 0);
    add_tri(mx, 0, 0, 0, mx, 0, 0, 0, mx);
    add_tri(mn, 0, 0, 0, mn, 0, 0, 0, mn);
    add_tri(-1, 0, 0, 0, -1, 0, 0, 0, -2);
    add_tri(32'sh12345, -32'sh6789a, 32'sh100, 32'sh40000, 32'sh3, -32'sh1, -7, 32'sh55555, 9);

    // Random triangles: mostly general, some with repeated or collinear vertices.
    for (int n = 0; n < N_RANDOM; n++) begin
      style = $urandom_range(2);
      for (int i = 0; i < 9; i++) v[i] = rand_coord(style);
      case ($urandom_range(9))
        0: for (int i = 0; i < 3; i++) v[3 + i] = v[i];
        1: for (int i = 0; i < 3; i++) v[6 + i] = v[3 + i];
        2: for (int i = 0; i < 3; i++) v[6 + i] = 2 * v[3 + i] - v[i];
        default: ;
      endcase
      add_tri(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]);
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_tris.size() == 0 && !in_valid && expected_words.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

endmodule
